### rtl/core/hdf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hdf_pkg
// Shared types and constants of the hysteresis debounce filter.
// ---------------------------------------------------------------------------
package hdf_pkg;

	// Field widths
	localparam int SAMPLE_WIDTH  = 16;
	localparam int ELAPSED_WIDTH = 16;
	localparam int ACC_WIDTH     = 24;
	localparam int OUT_CNT_WIDTH = 32;
	localparam int OUT_DUR_WIDTH = 40;
	localparam int CFG_IDX_WIDTH = 2;
	localparam int CFG_DAT_WIDTH = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_WIDTH-1:0] REG_UPPER_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_LOWER_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE_TIME   = 2'd2;

	// Register reset values: 0.7 and 0.3 in Q2.14
	localparam logic signed [SAMPLE_WIDTH-1:0] UPPER_RESET = 16'sd11469;
	localparam logic signed [SAMPLE_WIDTH-1:0] LOWER_RESET = 16'sd4915;
	localparam logic [ACC_WIDTH-1:0]           DEBOUNCE_RESET = '0;

	typedef enum logic [1:0] {
		LVL_UNKNOWN = 2'd0,
		LVL_LOW     = 2'd1,
		LVL_HIGH    = 2'd2
	} level_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE      = 2'd0,
		KIND_CLEAR_LEVEL = 2'd1,
		KIND_CLEAR_STATS = 2'd2
	} kind_t;

	// Level tracking state
	typedef struct packed {
		level_t                 confirmed;
		level_t                 pending;
		logic [ACC_WIDTH-1:0]   acc;
	} level_state_t;

	// Per-item flags
	typedef struct packed {
		logic changed;
		logic bounced;
	} step_flags_t;

endpackage : hdf_pkg
`default_nettype wire

### rtl/core/hdf_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hdf_step
// Next-state logic for one item: threshold compare, debounce accumulate,
// level confirm and saturating statistics update.
// ---------------------------------------------------------------------------
module hdf_step
	import hdf_pkg::*;
#(
	parameter int COUNT_WIDTH    = 32,
	parameter int DURATION_WIDTH = 40
) (
	input  wire kind_t                          kind,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
	input  wire logic [ELAPSED_WIDTH-1:0]       elapsed,
	input  wire logic signed [SAMPLE_WIDTH-1:0] upper_threshold,
	input  wire logic signed [SAMPLE_WIDTH-1:0] lower_threshold,
	input  wire logic [ACC_WIDTH-1:0]           debounce_time,
	input  wire level_state_t                   lvl_cur,
	input  wire logic [COUNT_WIDTH-1:0]         changes_cur,
	input  wire logic [COUNT_WIDTH-1:0]         bounces_cur,
	input  wire logic [COUNT_WIDTH-1:0]         updates_cur,
	input  wire logic [DURATION_WIDTH-1:0]      high_cur,
	input  wire logic [DURATION_WIDTH-1:0]      low_cur,
	output level_state_t                        lvl_nxt,
	output logic [COUNT_WIDTH-1:0]              changes_nxt,
	output logic [COUNT_WIDTH-1:0]              bounces_nxt,
	output logic [COUNT_WIDTH-1:0]              updates_nxt,
	output logic [DURATION_WIDTH-1:0]           high_nxt,
	output logic [DURATION_WIDTH-1:0]           low_nxt,
	output step_flags_t                         flags
);

	level_t                      target;
	logic [ACC_WIDTH-1:0]        acc_base;
	logic [ACC_WIDTH:0]          acc_sum;
	logic [ACC_WIDTH-1:0]        acc_new;
	logic [COUNT_WIDTH-1:0]      changes_inc;
	logic [COUNT_WIDTH-1:0]      bounces_inc;
	logic [COUNT_WIDTH-1:0]      updates_inc;
	logic [DURATION_WIDTH:0]     dur_sum;
	logic [DURATION_WIDTH-1:0]   dur_base;
	logic [DURATION_WIDTH-1:0]   dur_new;
	logic                        credit_low;

	// Hysteresis target: upper test wins, in-band holds the level
	always_comb begin
		if (sample >= upper_threshold) begin
			target = LVL_HIGH;
		end else if (sample <= lower_threshold) begin
			target = LVL_LOW;
		end else begin
			target = lvl_cur.confirmed;
		end
	end

	// Debounce accumulator: restart on a new pending target, saturate
	always_comb begin
		acc_base = (target != lvl_cur.pending) ? '0 : lvl_cur.acc;
		acc_sum  = {1'b0, acc_base} + (ACC_WIDTH+1)'(elapsed);
		acc_new  = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];
	end

	// Saturating increments
	assign changes_inc = (&changes_cur) ? changes_cur : changes_cur + COUNT_WIDTH'(1);
	assign bounces_inc = (&bounces_cur) ? bounces_cur : bounces_cur + COUNT_WIDTH'(1);
	assign updates_inc = (&updates_cur) ? updates_cur : updates_cur + COUNT_WIDTH'(1);

	// Duration credit: leaving high goes to low time, else high time
	always_comb begin
		credit_low = (lvl_cur.confirmed == LVL_HIGH);
		dur_base   = credit_low ? low_cur : high_cur;
		dur_sum    = {1'b0, dur_base} + (DURATION_WIDTH+1)'(elapsed);
		dur_new    = dur_sum[DURATION_WIDTH] ? '1 : dur_sum[DURATION_WIDTH-1:0];
	end

	// Next state per item kind
	always_comb begin
		lvl_nxt       = lvl_cur;
		changes_nxt   = changes_cur;
		bounces_nxt   = bounces_cur;
		updates_nxt   = updates_cur;
		high_nxt      = high_cur;
		low_nxt       = low_cur;
		flags.changed = 1'b0;
		flags.bounced = 1'b0;
		case (kind)
			KIND_SAMPLE: begin
				updates_nxt = updates_inc;
				if (debounce_time != '0) begin
					if (target != lvl_cur.confirmed) begin
						if (acc_new >= debounce_time) begin
							lvl_nxt.confirmed = target;
							lvl_nxt.pending   = LVL_UNKNOWN;
							lvl_nxt.acc       = '0;
							flags.changed     = 1'b1;
						end else begin
							lvl_nxt.pending = target;
							lvl_nxt.acc     = acc_new;
							bounces_nxt     = bounces_inc;
							flags.bounced   = 1'b1;
						end
					end else begin
						lvl_nxt.pending = LVL_UNKNOWN;
						lvl_nxt.acc     = '0;
					end
				end else if (target != lvl_cur.confirmed && target != LVL_UNKNOWN) begin
					lvl_nxt.confirmed = target;
					flags.changed     = 1'b1;
				end
				// Credit the confirmed change
				if (flags.changed) begin
					changes_nxt = changes_inc;
					if (credit_low) begin
						low_nxt = dur_new;
					end else begin
						high_nxt = dur_new;
					end
				end
			end
			KIND_CLEAR_LEVEL: begin
				lvl_nxt.confirmed = LVL_UNKNOWN;
				lvl_nxt.pending   = LVL_UNKNOWN;
				lvl_nxt.acc       = '0;
			end
			KIND_CLEAR_STATS: begin
				changes_nxt = '0;
				bounces_nxt = '0;
				updates_nxt = '0;
				high_nxt    = '0;
				low_nxt     = '0;
			end
			default: begin
				// Unused kind: state holds
			end
		endcase
	end

endmodule : hdf_step
`default_nettype wire

### rtl/core/hysteresis_debounce_filter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted item sits in the input register, then its result in the
// result register, where it holds until taken. State update is a single
// compare/add pass; throughput is one item per cycle while results are taken.
// Reset: arst_n clears level state, statistics and both pipeline valids, and
// loads the threshold and debounce registers with their defaults.
// ---------------------------------------------------------------------------
// hysteresis_debounce_filter_unit
// Schmitt trigger with debounce hold-off and saturating level statistics.
// ---------------------------------------------------------------------------
module hysteresis_debounce_filter_unit
	import hdf_pkg::*;
#(
	parameter int COUNT_WIDTH    = 32,
	parameter int DURATION_WIDTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// Input items
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [31:0]              s_tdata,   // sample[15:0], elapsed[31:16]
	input  wire logic [1:0]               s_tuser,   // kind[1:0]
	// Result items
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// level[1:0], changed[2], previous_level[4:3], bounce_filtered[5],
	// change_count[37:6], bounce_count[69:38], update_count[101:70],
	// high_time[141:102], low_time[181:142], zero fill[183:182]
	output logic [183:0]                  m_tdata,
	// Configuration writes
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  wire logic [CFG_DAT_WIDTH-1:0] cfg_data
);

	// Configuration registers
	logic signed [SAMPLE_WIDTH-1:0] upper_q;
	logic signed [SAMPLE_WIDTH-1:0] lower_q;
	logic [ACC_WIDTH-1:0]           debounce_q;

	// Input register
	logic                           valid_s1;
	kind_t                          kind_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic [ELAPSED_WIDTH-1:0]       elapsed_s1;

	// Filter state
	level_state_t                   lvl_q;
	logic [COUNT_WIDTH-1:0]         changes_q;
	logic [COUNT_WIDTH-1:0]         bounces_q;
	logic [COUNT_WIDTH-1:0]         updates_q;
	logic [DURATION_WIDTH-1:0]      high_q;
	logic [DURATION_WIDTH-1:0]      low_q;

	// Next state
	level_state_t                   lvl_nxt;
	logic [COUNT_WIDTH-1:0]         changes_nxt;
	logic [COUNT_WIDTH-1:0]         bounces_nxt;
	logic [COUNT_WIDTH-1:0]         updates_nxt;
	logic [DURATION_WIDTH-1:0]      high_nxt;
	logic [DURATION_WIDTH-1:0]      low_nxt;
	step_flags_t                    flags;

	// Result register
	logic                           valid_s2;
	level_t                         level_s2;
	level_t                         prev_s2;
	step_flags_t                    flags_s2;
	logic [OUT_CNT_WIDTH-1:0]       changes_s2;
	logic [OUT_CNT_WIDTH-1:0]       bounces_s2;
	logic [OUT_CNT_WIDTH-1:0]       updates_s2;
	logic [OUT_DUR_WIDTH-1:0]       high_s2;
	logic [OUT_DUR_WIDTH-1:0]       low_s2;

	logic                           advance;
	logic                           in_fire;

	// Handshake: advance when the result slot is free or being taken
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign in_fire   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q    <= UPPER_RESET;
			lower_q    <= LOWER_RESET;
			debounce_q <= DEBOUNCE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_UPPER_THRESHOLD: upper_q    <= cfg_data[SAMPLE_WIDTH-1:0];
				REG_LOWER_THRESHOLD: lower_q    <= cfg_data[SAMPLE_WIDTH-1:0];
				REG_DEBOUNCE_TIME:   debounce_q <= cfg_data[ACC_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1    <= kind_t'(s_tuser);
			sample_s1  <= s_tdata[15:0];
			elapsed_s1 <= s_tdata[31:16];
		end
	end

	hdf_step #(
		.COUNT_WIDTH    (COUNT_WIDTH),
		.DURATION_WIDTH (DURATION_WIDTH)
	) u_step (
		.kind            (kind_s1),
		.sample          (sample_s1),
		.elapsed         (elapsed_s1),
		.upper_threshold (upper_q),
		.lower_threshold (lower_q),
		.debounce_time   (debounce_q),
		.lvl_cur         (lvl_q),
		.changes_cur     (changes_q),
		.bounces_cur     (bounces_q),
		.updates_cur     (updates_q),
		.high_cur        (high_q),
		.low_cur         (low_q),
		.lvl_nxt         (lvl_nxt),
		.changes_nxt     (changes_nxt),
		.bounces_nxt     (bounces_nxt),
		.updates_nxt     (updates_nxt),
		.high_nxt        (high_nxt),
		.low_nxt         (low_nxt),
		.flags           (flags)
	);

	// Update filter state as the item passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q.confirmed <= LVL_UNKNOWN;
			lvl_q.pending   <= LVL_UNKNOWN;
			lvl_q.acc       <= '0;
			changes_q       <= '0;
			bounces_q       <= '0;
			updates_q       <= '0;
			high_q          <= '0;
			low_q           <= '0;
		end else if (advance) begin
			lvl_q     <= lvl_nxt;
			changes_q <= changes_nxt;
			bounces_q <= bounces_nxt;
			updates_q <= updates_nxt;
			high_q    <= high_nxt;
			low_q     <= low_nxt;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			level_s2   <= lvl_nxt.confirmed;
			prev_s2    <= lvl_q.confirmed;
			flags_s2   <= flags;
			changes_s2 <= OUT_CNT_WIDTH'(changes_nxt);
			bounces_s2 <= OUT_CNT_WIDTH'(bounces_nxt);
			updates_s2 <= OUT_CNT_WIDTH'(updates_nxt);
			high_s2    <= OUT_DUR_WIDTH'(high_nxt);
			low_s2     <= OUT_DUR_WIDTH'(low_nxt);
		end
	end

	// Pack the result item
	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, low_s2, high_s2, updates_s2, bounces_s2, changes_s2,
		flags_s2.bounced, prev_s2, flags_s2.changed, level_s2};

endmodule : hysteresis_debounce_filter_unit
`default_nettype wire

### dv/hysteresis_debounce_filter_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hysteresis_debounce_filter_unit_test
// Self-checking bench for the hysteresis debounce filter. A short table of
// directed items, where the obvious rows carry their result by hand, is
// followed by a long hold that saturates the debounce accumulator and by
// random phases under changing thresholds and debounce times. Each accepted
// item runs through a local level tracker, and every result item is compared
// field by field with the oldest prediction. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module hysteresis_debounce_filter_unit_test;
	import hdf_pkg::*;

	localparam logic [1:0]               KIND_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED   = 2'd3;
	localparam int                       ITEM_TARGET  = 1200;
	localparam int                       QUIET_LIMIT  = 1000;
	localparam int                       PRINT_LIMIT  = 100;

	// One result item, laid out as on m_tdata
	typedef struct packed {
		logic [1:0]  pad;
		logic [39:0] low_time;
		logic [39:0] high_time;
		logic [31:0] update_count;
		logic [31:0] bounce_count;
		logic [31:0] change_count;
		logic        bounce_filtered;
		level_t      previous_level;
		logic        changed;
		level_t      level;
	} filter_result_t;

	// One directed step: a register setting or an item
	typedef struct {
		bit             load;
		logic [23:0]    up_val;
		logic [23:0]    lo_val;
		logic [23:0]    db_val;
		bit             poke;
		logic [1:0]     kind;
		logic [15:0]    smp;
		logic [15:0]    ela;
		bit             typed;
		filter_result_t want;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [31:0]              s_tdata;   // sample[15:0], elapsed[31:16]
	logic [1:0]               s_tuser;   // kind[1:0]
	logic                     m_tvalid;
	logic                     m_tready;
	// level[1:0], changed[2], previous_level[4:3], bounce_filtered[5],
	// change_count[37:6], bounce_count[69:38], update_count[101:70],
	// high_time[141:102], low_time[181:142], zero fill[183:182]
	logic [183:0]             m_tdata;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_WIDTH-1:0] cfg_index;
	logic [CFG_DAT_WIDTH-1:0] cfg_data;

	// Level tracker state and its copy of the registers
	logic signed [15:0] upper_thr;
	logic signed [15:0] lower_thr;
	logic [23:0]        hold_ticks;
	level_t             cur_level;
	level_t             pend_level;
	logic [23:0]        hold_acc;
	logic [31:0]        n_changes;
	logic [31:0]        n_bounces;
	logic [31:0]        n_updates;
	logic [39:0]        t_high;
	logic [39:0]        t_low;

	filter_result_t results_due[$];
	int             mismatches = 0;
	int             items_sent = 0;
	int             quiet_cycles;
	bit             src_quiet;
	bit             snk_quiet;

	hysteresis_debounce_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// Count a confirmed change and credit its elapsed ticks
	function automatic void book_change(level_t old, logic [15:0] ela);
		logic [40:0] sum;
		if (n_changes != '1)
			n_changes = n_changes + 1;
		if (ela != 0) begin
			if (old == LVL_HIGH) begin
				sum = {1'b0, t_low} + 41'(ela);
				t_low = sum[40] ? '1 : sum[39:0];
			end else begin
				sum = {1'b0, t_high} + 41'(ela);
				t_high = sum[40] ? '1 : sum[39:0];
			end
		end
	endfunction

	// Advance the level tracker by one item and return its result
	function automatic filter_result_t filter_step(logic [1:0] kind,
		logic signed [15:0] smp, logic [15:0] ela);
		filter_result_t r;
		level_t         target;
		logic [24:0]    acc_sum;
		r = '0;
		r.previous_level = cur_level;
		case (kind)
			KIND_SAMPLE: begin
				target = cur_level;
				if (smp >= upper_thr)
					target = LVL_HIGH;
				else if (smp <= lower_thr)
					target = LVL_LOW;
				if (hold_ticks != 0) begin
					if (target != cur_level) begin
						// restart the hold when the pending target moves
						if (target != pend_level) begin
							pend_level = target;
							hold_acc = '0;
						end
						acc_sum = {1'b0, hold_acc} + 25'(ela);
						hold_acc = acc_sum[24] ? '1 : acc_sum[23:0];
						if (hold_acc >= hold_ticks) begin
							book_change(cur_level, ela);
							cur_level = pend_level;
							r.changed = 1'b1;
							hold_acc = '0;
							pend_level = LVL_UNKNOWN;
						end else begin
							if (n_bounces != '1)
								n_bounces = n_bounces + 1;
							r.bounce_filtered = 1'b1;
						end
					end else begin
						hold_acc = '0;
						pend_level = LVL_UNKNOWN;
					end
				end else if (target != cur_level && target != LVL_UNKNOWN) begin
					book_change(cur_level, ela);
					cur_level = target;
					r.changed = 1'b1;
				end
				if (n_updates != '1)
					n_updates = n_updates + 1;
			end
			KIND_CLEAR_LEVEL: begin
				cur_level = LVL_UNKNOWN;
				pend_level = LVL_UNKNOWN;
				hold_acc = '0;
			end
			KIND_CLEAR_STATS: begin
				n_changes = '0;
				n_bounces = '0;
				n_updates = '0;
				t_high = '0;
				t_low = '0;
			end
			default: begin
			end
		endcase
		r.level = cur_level;
		r.change_count = n_changes;
		r.bounce_count = n_bounces;
		r.update_count = n_updates;
		r.high_time = t_high;
		r.low_time = t_low;
		return r;
	endfunction

	function automatic filter_result_t mk_result(level_t lv, logic ch, level_t pv,
		logic bf, logic [31:0] nc, logic [31:0] nb, logic [31:0] nu,
		logic [39:0] th, logic [39:0] tl);
		filter_result_t r;
		r = '0;
		r.level = lv;
		r.changed = ch;
		r.previous_level = pv;
		r.bounce_filtered = bf;
		r.change_count = nc;
		r.bounce_count = nb;
		r.update_count = nu;
		r.high_time = th;
		r.low_time = tl;
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [23:0] up, logic [23:0] lo,
		logic [23:0] db, bit poke);
		stim_row_t r;
		r.load = 1'b1;
		r.up_val = up;
		r.lo_val = lo;
		r.db_val = db;
		r.poke = poke;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic stim_row_t item_row(logic [1:0] kind, logic [15:0] smp,
		logic [15:0] ela);
		stim_row_t r;
		r.load = 1'b0;
		r.kind = kind;
		r.smp = smp;
		r.ela = ela;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(logic [1:0] kind, logic [15:0] smp,
		logic [15:0] ela, filter_result_t want);
		stim_row_t r;
		r = item_row(kind, smp, ela);
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic int draw_gap(bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 9));
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(string name, logic [39:0] got, logic [39:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Send one item; the tracker runs at the accepting edge
	task automatic send_item(logic [1:0] kind, logic [15:0] smp, logic [15:0] ela,
		bit typed, filter_result_t want);
		filter_result_t predicted;
		int             gap;
		gap = draw_gap(src_quiet);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {ela, smp};
		s_tuser <= kind;
		do @(posedge clk); while (!s_tready);
		predicted = filter_step(kind, smp, ela);
		results_due.push_back(typed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Drain, then write every register back to back
	task automatic load_config(logic [23:0] up, logic [23:0] lo, logic [23:0] db,
		bit poke);
		logic [CFG_IDX_WIDTH-1:0] idx[$];
		logic [23:0]              val[$];
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		idx = '{REG_UPPER_THRESHOLD, REG_LOWER_THRESHOLD, REG_DEBOUNCE_TIME};
		val = '{up, lo, db};
		if (poke) begin
			idx.push_front(REG_UNUSED);
			val.push_front(24'($urandom));
		end
		foreach (idx[i]) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_UPPER_THRESHOLD: upper_thr = val[i][15:0];
				REG_LOWER_THRESHOLD: lower_thr = val[i][15:0];
				REG_DEBOUNCE_TIME:   hold_ticks = val[i];
				default: begin
				end
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Compare each result item with the oldest prediction
	always @(posedge clk) begin : result_check
		filter_result_t got;
		filter_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (results_due.size() == 0) begin
				report_mismatch("result item with no item outstanding");
			end else begin
				want = results_due.pop_front();
				check_field("level", 40'(got.level), 40'(want.level));
				check_field("changed", 40'(got.changed), 40'(want.changed));
				check_field("previous_level", 40'(got.previous_level),
					40'(want.previous_level));
				check_field("bounce_filtered", 40'(got.bounce_filtered),
					40'(want.bounce_filtered));
				check_field("change_count", 40'(got.change_count), 40'(want.change_count));
				check_field("bounce_count", 40'(got.bounce_count), 40'(want.bounce_count));
				check_field("update_count", 40'(got.update_count), 40'(want.update_count));
				check_field("high_time", got.high_time, want.high_time);
				check_field("low_time", got.low_time, want.low_time);
			end
		end
	end

	// Abort when no channel moves an item for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog expired after %0d idle cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: idle at random before each item, except in quiet spells
	initial begin : result_sink
		int gap;
		m_tready = 1'b0;
		snk_quiet = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 49) == 0)
				snk_quiet = !snk_quiet;
			gap = draw_gap(snk_quiet);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Stimulus: directed table, accumulator saturation, random phases
	initial begin : stimulus
		stim_row_t   dir_rows[$];
		int          u;
		int          l;
		int          lo_b;
		int          hi_b;
		int          region;
		int          run;
		int          pick;
		int          plen;
		logic [23:0] db;
		logic [1:0]  kind;
		logic [15:0] smp;
		logic [15:0] ela;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		src_quiet = 1'b0;

		upper_thr = UPPER_RESET;
		lower_thr = LOWER_RESET;
		hold_ticks = DEBOUNCE_RESET;
		cur_level = LVL_UNKNOWN;
		pend_level = LVL_UNKNOWN;
		hold_acc = '0;
		n_changes = '0;
		n_bounces = '0;
		n_updates = '0;
		t_high = '0;
		t_low = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Defaults after reset: thresholds 0.7 / 0.3, no debouncing
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'h0000, 16'h0000,
			mk_result(LVL_LOW, 1, LVL_UNKNOWN, 0, 1, 0, 1, 0, 0)));
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'h7FFF, 16'hFFFF,
			mk_result(LVL_HIGH, 1, LVL_LOW, 0, 2, 0, 2, 65535, 0)));
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'h8000, 16'hFFFF,
			mk_result(LVL_LOW, 1, LVL_HIGH, 0, 3, 0, 3, 65535, 65535)));
		// between the thresholds the level holds
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'd8000, 16'd100,
			mk_result(LVL_LOW, 0, LVL_LOW, 0, 3, 0, 4, 65535, 65535)));
		// unused kind leaves everything alone
		dir_rows.push_back(typed_row(KIND_UNUSED, 16'h5555, 16'hAAAA,
			mk_result(LVL_LOW, 0, LVL_LOW, 0, 3, 0, 4, 65535, 65535)));
		dir_rows.push_back(typed_row(KIND_CLEAR_LEVEL, 16'hAAAA, 16'h5555,
			mk_result(LVL_UNKNOWN, 0, LVL_LOW, 0, 3, 0, 4, 65535, 65535)));
		// from unknown, a mid sample has nothing to hold
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'd8000, 16'd7,
			mk_result(LVL_UNKNOWN, 0, LVL_UNKNOWN, 0, 3, 0, 5, 65535, 65535)));
		dir_rows.push_back(typed_row(KIND_CLEAR_STATS, 16'hFFFF, 16'hFFFF,
			mk_result(LVL_UNKNOWN, 0, LVL_UNKNOWN, 0, 0, 0, 0, 0, 0)));
		// exactly on each threshold
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'd11469, 16'd5,
			mk_result(LVL_HIGH, 1, LVL_UNKNOWN, 0, 1, 0, 1, 5, 0)));
		dir_rows.push_back(typed_row(KIND_SAMPLE, 16'd4915, 16'd3,
			mk_result(LVL_LOW, 1, LVL_HIGH, 0, 2, 0, 2, 5, 3)));
		// crossed thresholds: the upper test wins
		dir_rows.push_back(cfg_row(24'h5AFF9C, 24'hC30064, 24'd0, 1'b0));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'h0000, 16'd9));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'd100, 16'd1));
		// debounce of 10 ticks: hold off, restart, zero elapsed, confirm
		dir_rows.push_back(cfg_row(24'h5AFF9C, 24'hC30064, 24'd10, 1'b1));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'hFF38, 16'd4));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'hFF38, 16'd4));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'h0000, 16'd4));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'hFF38, 16'd6));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'hFF38, 16'd0));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'hFF38, 16'd4));
		// extreme thresholds: every sample targets high
		dir_rows.push_back(cfg_row(24'h008000, 24'hFF7FFF, 24'd10, 1'b0));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'h8000, 16'd20));
		// widest band, no debouncing
		dir_rows.push_back(cfg_row(24'h337FFF, 24'h008000, 24'd0, 1'b0));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'h7FFF, 16'd2));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'h8000, 16'd2));
		dir_rows.push_back(item_row(KIND_SAMPLE, 16'h0000, 16'd2));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].load)
				load_config(dir_rows[i].up_val, dir_rows[i].lo_val, dir_rows[i].db_val,
					dir_rows[i].poke);
			else
				send_item(dir_rows[i].kind, dir_rows[i].smp, dir_rows[i].ela,
					dir_rows[i].typed, dir_rows[i].want);
		end

		// Longest debounce: the accumulator saturates, and the saturated value confirms
		load_config(24'(UPPER_RESET), 24'(LOWER_RESET), 24'hFFFFFF, 1'b0);
		src_quiet = 1'b1;
		send_item(KIND_CLEAR_LEVEL, 16'h0000, 16'h0000, 1'b0, '0);
		repeat (258)
			send_item(KIND_SAMPLE, 16'h7FFF, 16'hFFFF, 1'b0, '0);

		// Random phases, each under a fresh register setting
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 5))
				0: begin
					u = UPPER_RESET;
					l = LOWER_RESET;
				end
				1: begin
					l = $urandom_range(0, 32767);
					u = l - int'($urandom_range(0, l + 32768));
				end
				2: begin
					u = $urandom_range(0, 1) ? 32767 : -32768;
					l = $urandom_range(0, 1) ? 32767 : -32768;
				end
				default: begin
					l = int'($urandom_range(0, 65534)) - 32768;
					u = l + 1 + int'($urandom_range(0, 32766 - l));
				end
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: db = 24'd0;
				3:       db = 24'($urandom);
				4:       db = 24'd1;
				default: db = 24'($urandom_range(1, 40));
			endcase
			load_config({8'($urandom), 16'(u)}, {8'($urandom), 16'(l)}, db,
				$urandom_range(0, 7) == 0);
			src_quiet = $urandom_range(0, 3) == 0;
			plen = $urandom_range(20, 80);
			run = 0;
			region = 0;
			repeat (plen) begin
				// runs toward one level so the hold-off can confirm
				if (run == 0) begin
					region = $urandom_range(0, 2);
					run = $urandom_range(1, 6);
				end
				run--;
				pick = $urandom_range(0, 99);
				if (pick < 3)
					kind = KIND_CLEAR_LEVEL;
				else if (pick < 5)
					kind = KIND_CLEAR_STATS;
				else if (pick < 7)
					kind = KIND_UNUSED;
				else
					kind = KIND_SAMPLE;
				case (region)
					0: begin
						lo_b = upper_thr;
						hi_b = 32767;
					end
					1: begin
						lo_b = -32768;
						hi_b = lower_thr;
					end
					default: begin
						lo_b = int'(lower_thr) + 1;
						hi_b = int'(upper_thr) - 1;
					end
				endcase
				if (lo_b > hi_b) begin
					lo_b = -32768;
					hi_b = 32767;
				end
				smp = 16'(lo_b + int'($urandom_range(0, hi_b - lo_b)));
				if ($urandom_range(0, 19) == 0)
					smp = 16'($urandom);
				if ($urandom_range(0, 15) == 0)
					ela = 16'($urandom);
				else
					ela = 16'($urandom_range(0, 16));
				send_item(kind, smp, ela, 1'b0, '0);
			end
		end

		// Drain and let any stray result item show up
		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
